// ===== rtl/tccs_pkg.sv =====
// Shared types and constants for the text console cursor/scroll engine.
// No dependencies; imported by tccs_ctrl and the top module.
package tccs_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h07;
  localparam logic [15:0] BLANK_RESET = {ATTR_RESET, SPACE_CODE};

  // configuration port: byte address width and register index bit
  localparam int PADDR_W = 3;
  localparam logic REG_ATTR = 1'b0;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
  } tccs_res_t;

endpackage

// ===== rtl/tccs_mem.sv =====
// Cell store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module tccs_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tccs_ctrl.sv =====
// Sequencer: cursor state, shared address counter, store copy/fill sweeps.
// Depends on tccs_pkg; drives one tccs_mem instance.
module tccs_ctrl #(
  parameter int ROWS = tccs_pkg::ROWS_DEF,
  parameter int COLS = tccs_pkg::COLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic [7:0]          in_char_code,
  input  logic [10:0]         in_cell_index,
  input  logic [7:0]          attr,
  input  logic                res_ready,
  output logic                res_vld,
  output tccs_pkg::tccs_res_t res
);
  import tccs_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int NCOPY = (ROWS - 1) * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_COPY = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   fill_r, fill_nxt;
  logic          pend_r, pend_nxt;
  logic [15:0]   cellv_r, cellv_nxt;
  logic          scr_r, scr_nxt;
  logic          rdok_r, rdok_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic [AW-1:0] pos;
  logic          accept;
  logic          wrap;

  tccs_mem #(.DEPTH(CELLS), .AW(AW)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign pos      = AW'(row_r * COLS) + AW'(col_r);

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cnt_nxt   = cnt_r;
    fill_nxt  = fill_r;
    pend_nxt  = pend_r;
    cellv_nxt = cellv_r;
    scr_nxt   = scr_r;
    rdok_nxt  = rdok_r;
    we        = 1'b0;
    waddr     = cnt_r;
    wdata     = fill_r;
    raddr     = AW'(in_cell_index);
    res_vld   = 1'b0;
    wrap      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cellv_nxt = '0;
          scr_nxt   = 1'b0;
          case (in_action)
            ACT_PUT: begin
              if (in_char_code == NEWLINE_CODE) begin
                wrap = 1'b1;
              end else begin
                we        = 1'b1;
                waddr     = pos;
                wdata     = {attr, in_char_code};
                cellv_nxt = {attr, in_char_code};
                if (col_r == CW'(COLS - 1)) begin
                  wrap = 1'b1;
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end
              state_nxt = S_RES;
              if (wrap) begin
                col_nxt = '0;
                if (row_r == RW'(ROWS - 1)) begin
                  // bottom line: shift the screen up one row
                  scr_nxt   = 1'b1;
                  cnt_nxt   = '0;
                  pend_nxt  = 1'b1;
                  state_nxt = S_COPY;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end
            end
            ACT_READ: begin
              rdok_nxt  = (32'(in_cell_index) < CELLS);
              state_nxt = S_RD;
            end
            ACT_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              cnt_nxt   = '0;
              fill_nxt  = {attr, SPACE_CODE};
              pend_nxt  = 1'b1;
              state_nxt = S_FILL;
            end
            default: begin
              state_nxt = S_RES;
            end
          endcase
        end
      end
      S_RD: begin
        cellv_nxt = rdok_r ? rdata : '0;
        state_nxt = S_RES;
      end
      S_COPY: begin
        // read runs one cell ahead of the write
        raddr = AW'(cnt_r + AW'(COLS));
        if (cnt_r != '0) begin
          we    = 1'b1;
          waddr = cnt_r - 1'b1;
          wdata = rdata;
        end
        if (cnt_r == AW'(NCOPY)) begin
          fill_nxt  = {attr, SPACE_CODE};
          state_nxt = S_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FILL: begin
        we = 1'b1;
        if (cnt_r == AW'(CELLS - 1)) begin
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? S_RES : S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RES: begin
        if (res_ready) begin
          res_vld   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.cell_value = cellv_r;
    res.cursor_row = 5'(row_r);
    res.cursor_col = 7'(col_r);
    res.scrolled   = scr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      row_r   <= '0;
      col_r   <= '0;
      cnt_r   <= '0;
      fill_r  <= BLANK_RESET;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cellv_r <= cellv_nxt;
    scr_r   <= scr_nxt;
    rdok_r  <= rdok_nxt;
  end

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// A clear fills all ROWS*COLS cells; a put that scrolls copies (ROWS-1)*COLS
// cells up one row, then fills the COLS cells of the bottom row.
// Throughput: one item at a time through the single-port-write cell store.
// Reset: cursor homes, attribute returns to 7, then a clearing pass over all
// ROWS*COLS cells writes blank cells while in_stall stays high.
// Depends on tccs_pkg, tccs_ctrl and tccs_mem.
module text_console_cursor_scroll #(
  parameter int ROWS = tccs_pkg::ROWS_DEF,
  parameter int COLS = tccs_pkg::COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [7:0]                   in_char_code,
  input  logic [10:0]                  in_cell_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_cell_value,
  output logic [4:0]                   out_cursor_row,
  output logic [6:0]                   out_cursor_col,
  output logic                         out_scrolled,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tccs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tccs_pkg::*;

  logic [7:0] attr_r;
  logic       out_valid_r;
  tccs_res_t  out_r;
  tccs_res_t  res;
  logic       res_vld;
  logic       res_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ATTR) ? {24'd0, attr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ATTR) begin
      attr_r <= pwdata[7:0];
    end
  end

  assign res_ready = !out_valid_r || !out_stall;

  tccs_ctrl #(.ROWS(ROWS), .COLS(COLS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_char_code (in_char_code),
    .in_cell_index(in_cell_index),
    .attr         (attr_r),
    .res_ready    (res_ready),
    .res_vld      (res_vld),
    .res          (res)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_r.cell_value;
  assign out_cursor_row = out_r.cursor_row;
  assign out_cursor_col = out_r.cursor_col;
  assign out_scrolled   = out_r.scrolled;

  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("store clearing pass not started after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer took an item without leaving idle");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |->
      out_cursor_col == 7'd0 && out_cursor_row == 5'(ROWS - 1))
    else $error("scroll beat with cursor off the bottom line start");

endmodule
